// ===== rtl/core/zst_pkg.sv =====
package zst_pkg;

   // Configuration register widths
   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   // Row counter reaches frame_height + 1 during the flush
   localparam int ROW_W  = 13;

   // CSR port geometry
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Register reset values and legal limits
   localparam logic [FW_W-1:0] FW_RESET     = 11'd1024;
   localparam logic [FH_W-1:0] FH_RESET     = 13'd4096;
   localparam logic [FH_W-1:0] HEIGHT_LIMIT = 13'd4096;
   localparam int              MIN_DIM      = 3;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_FRAME_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_SUB_ITERATION = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   // Position flags of the pixel entering the window stage
   typedef struct packed {
      logic skip;       // drain beat before the frame is complete
      logic flushing;   // beat lies past the last image row
      logic last_px;    // beat produces the final result of the frame
      logic emit;       // beat produces a result
      logic interior;   // delayed pixel is not on the image border
   } pos_flags_type;

endpackage

// ===== rtl/core/zst_ram.sv =====
module zst_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/zst_csr.sv =====
module zst_csr
   import zst_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_AW-1:0]         csr_paddr,
   input  logic [CSR_DW-1:0]         csr_pwdata,
   output logic [CSR_DW-1:0]         csr_prdata,
   output logic                      csr_pready,
   output logic [$clog2(MAX_WIDTH+1)-1:0] width_used,
   output logic [ROW_W-1:0]          height_used,
   output logic                      sub_iter
);

   localparam int          WW      = $clog2(MAX_WIDTH + 1);
   localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
   localparam logic [31:0] MIN_32  = 32'(MIN_DIM);

   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;
   logic            sub_iteration_ff;
   reg_index_type   reg_sel;
   logic            wr_hit;
   logic [31:0]     fw_ext;
   logic [31:0]     w_sel;
   logic [FH_W-1:0] h_sel;

   assign reg_sel    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FW_RESET;
         frame_height_ff  <= FH_RESET;
         sub_iteration_ff <= 1'b0;
      end else if (wr_hit) begin
         case (reg_sel)
            REG_FRAME_WIDTH:   frame_width_ff   <= csr_pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff  <= csr_pwdata[FH_W-1:0];
            REG_SUB_ITERATION: sub_iteration_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH:   csr_prdata = CSR_DW'(frame_width_ff);
         REG_FRAME_HEIGHT:  csr_prdata = CSR_DW'(frame_height_ff);
         REG_SUB_ITERATION: csr_prdata = CSR_DW'(sub_iteration_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Saturate width and height to their legal ranges
   assign fw_ext = 32'(frame_width_ff);

   always_comb begin
      if (fw_ext < MIN_32) begin
         w_sel = MIN_32;
      end else if (fw_ext > MAX_W32) begin
         w_sel = MAX_W32;
      end else begin
         w_sel = fw_ext;
      end
   end

   always_comb begin
      if (frame_height_ff < FH_W'(MIN_DIM)) begin
         h_sel = FH_W'(MIN_DIM);
      end else if (frame_height_ff > HEIGHT_LIMIT) begin
         h_sel = HEIGHT_LIMIT;
      end else begin
         h_sel = frame_height_ff;
      end
   end

   assign width_used  = w_sel[WW-1:0];
   assign height_used = ROW_W'(h_sel);
   assign sub_iter    = sub_iteration_ff;

endmodule

// ===== rtl/core/zst_scan.sv =====
module zst_scan
   import zst_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               drain,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_used,
   input  logic [ROW_W-1:0]                   height_used,
   output logic [$clog2(MAX_WIDTH)-1:0]       col_cur,
   output pos_flags_type                      flags
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             wrap;
   logic [CW-1:0]    col_n;
   logic [ROW_W-1:0] row_n;
   logic [CW-1:0]    col_eff;
   logic [WW-1:0]    col_inc;
   logic [ROW_W-1:0] pr;
   logic [WW-1:0]    pc;

   // Start the next row when the column ran past the width
   assign wrap  = WW'(col_ff) >= width_used;
   assign col_n = wrap ? '0 : col_ff;
   assign row_n = wrap ? row_ff + 1'b1 : row_ff;

   assign flags.flushing = row_n >= height_used;
   assign flags.last_px  = row_n > height_used;
   assign flags.skip     = !flags.flushing && drain;

   assign col_eff = flags.last_px ? '0 : col_n;
   assign col_cur = col_eff;

   assign flags.emit = (row_n >= ROW_W'(2)) || (row_n == ROW_W'(1) && col_eff != '0);

   // Position of the delayed pixel, one row and one column behind
   always_comb begin
      if (col_eff != '0) begin
         pr = row_n - 1'b1;
         pc = WW'(col_eff) - 1'b1;
      end else begin
         pr = row_n - ROW_W'(2);
         pc = width_used - 1'b1;
      end
   end

   assign flags.interior = flags.emit && (pr >= ROW_W'(1))
                           && (pr <= height_used - ROW_W'(2))
                           && (pc >= WW'(1)) && (pc <= width_used - WW'(2));

   // Advance the raster position
   assign col_inc = WW'(col_n) + 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.skip) begin
            col_in = col_n;
            row_in = row_n;
         end else if (flags.last_px) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= width_used) begin
            col_in = '0;
            row_in = row_n + 1'b1;
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = row_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // The final beat of a frame restarts the raster at the origin
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && !flags.skip && flags.last_px) |=> (row_ff == '0 && col_ff == '0))
      else $error("raster position not cleared after the final beat");

   // A skipped drain beat never moves past the current row
   a_skip_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && flags.skip) |=> (row_ff == $past(row_n)))
      else $error("drain beat advanced the row");

endmodule

// ===== rtl/core/zst_window.sv =====
module zst_window (
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  logic up_bit,
   input  logic mid_bit,
   input  logic new_bit,
   input  logic sub_iter,
   output logic center_bit,
   output logic remove_hit
);

   localparam logic [3:0] TRANS_ONE = 4'd1;
   localparam logic [3:0] NBR_MIN   = 4'd2;
   localparam logic [3:0] NBR_MAX   = 4'd6;

   // [row][col], col 2 is the newest column
   logic [2:0][2:0] win_ff, win_in;
   logic [7:0]      ring;
   logic [3:0]      trans;
   logic [3:0]      nbr;
   logic            m1, m2;

   // Shift one column into the 3x3 window
   assign win_in[0] = {up_bit,  win_ff[0][2:1]};
   assign win_in[1] = {mid_bit, win_ff[1][2:1]};
   assign win_in[2] = {new_bit, win_ff[2][2:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

   // Ring p2..p9, clockwise from the pixel above the center
   assign ring = {win_in[0][0], win_in[1][0], win_in[2][0], win_in[2][1],
                  win_in[2][2], win_in[1][2], win_in[0][2], win_in[0][1]};
   assign center_bit = win_in[1][1];

   // Count 0-to-1 transitions and set neighbors around the ring
   always_comb begin
      trans = '0;
      nbr   = '0;
      for (int i = 0; i < 8; i++) begin
         trans = trans + 4'(!ring[i] && ring[3'(i + 1)]);
         nbr   = nbr + 4'(ring[i]);
      end
   end

   // Products of the selected sub-iteration
   always_comb begin
      if (sub_iter) begin
         m1 = ring[0] & ring[2] & ring[6];
         m2 = ring[0] & ring[4] & ring[6];
      end else begin
         m1 = ring[0] & ring[2] & ring[4];
         m2 = ring[2] & ring[4] & ring[6];
      end
   end

   assign remove_hit = (trans == TRANS_ONE) && (nbr >= NBR_MIN) && (nbr <= NBR_MAX)
                       && !m1 && !m2;

endmodule

// ===== rtl/core/zhang_suen_thinning_pass.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_pixel_in, req_drain
// rsp      out        rsp_valid/rsp_stall  rsp_pixel_out, rsp_removed,
//                                          rsp_frame_last, rsp_frame_changed
// csr      in/out     APB psel/penable     frame_width, frame_height, sub_iteration
//
// One pixel beat per cycle while req_stall is low; the line-store RAM read sits in the first
// stage, the window shift and removal test in the second, the result in an output register.
// A result is written into the output register when its beat leaves stage 1.
// Results lag the pixel stream by one row plus one pixel; width+1 drain beats flush it.
// Reset is synchronous; a fill count replaces clearing the line stores.
// A stall on rsp holds the output register and backs up to req_stall.
module zhang_suen_thinning_pass
   import zst_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_pixel_in,
   input  logic              req_drain,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_pixel_out,
   output logic              rsp_removed,
   output logic              rsp_frame_last,
   output logic              rsp_frame_changed,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   logic [WW-1:0]    width_used;
   logic [ROW_W-1:0] height_used;
   logic             sub_iter;
   logic [CW-1:0]    col_cur;
   pos_flags_type    flags;
   logic             accept;
   logic             s0_go;

   // Stage 1 registers
   logic             s1_v_ff;
   logic [CW-1:0]    s1_col_ff;
   logic             s1_pix_ff;
   logic             s1_last_ff;
   logic             s1_emit_ff;
   logic             s1_int_ff;
   logic             fill_ok_ff;
   logic             byp_ff;
   logic [1:0]       byp_data_ff;
   logic [WW-1:0]    fill_ff;

   // Output register
   logic             o_v_ff;
   logic             o_pix_ff;
   logic             o_rem_ff;
   logic             o_last_ff;
   logic             o_chg_ff;
   logic             any_ff;

   logic             out_free;
   logic             s1_go;
   logic             ram_we;
   logic [1:0]       ram_wdata;
   logic [1:0]       ram_rdata;
   logic [1:0]       rd_bits;
   logic             center_bit;
   logic             remove_hit;
   logic             removed;

   zst_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .width_used  (width_used),
      .height_used (height_used),
      .sub_iter    (sub_iter)
   );

   assign accept = req_valid && !req_stall;
   assign s0_go  = accept && !flags.skip;

   zst_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .drain       (req_drain),
      .width_used  (width_used),
      .height_used (height_used),
      .col_cur     (col_cur),
      .flags       (flags)
   );

   // Flow control: stage 1 moves unless its result cannot enter the output register
   assign out_free  = !o_v_ff || !rsp_stall;
   assign s1_go     = s1_v_ff && (!s1_emit_ff || out_free);
   assign req_stall = s1_v_ff && !s1_go;

   // Line stores, packed as {upper, middle} per column
   assign ram_we    = s1_go;
   assign ram_wdata = {rd_bits[0], s1_pix_ff};

   zst_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wdata),
      .rd_en   (s0_go),
      .rd_addr (col_cur),
      .rd_data (ram_rdata)
   );

   // Bypass a same-column write, and read columns never written as zero
   assign rd_bits = byp_ff ? byp_data_ff : (fill_ok_ff ? ram_rdata : 2'b00);

   // Load stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s0_go) begin
         s1_v_ff <= 1'b1;
      end else if (s1_go) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_go) begin
         s1_col_ff   <= col_cur;
         s1_pix_ff   <= !flags.flushing && req_pixel_in;
         s1_last_ff  <= flags.last_px;
         s1_emit_ff  <= flags.emit;
         s1_int_ff   <= flags.interior;
         fill_ok_ff  <= WW'(col_cur) < fill_ff;
         byp_ff      <= ram_we && (s1_col_ff == col_cur);
         byp_data_ff <= ram_wdata;
      end
   end

   // Track how many leading columns of the line stores hold written data
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (ram_we && WW'(s1_col_ff) >= fill_ff) begin
         fill_ff <= WW'(s1_col_ff) + 1'b1;
      end
   end

   zst_window u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (s1_go),
      .up_bit     (rd_bits[1]),
      .mid_bit    (rd_bits[0]),
      .new_bit    (s1_pix_ff),
      .sub_iter   (sub_iter),
      .center_bit (center_bit),
      .remove_hit (remove_hit)
   );

   assign removed = s1_int_ff && center_bit && remove_hit;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         o_v_ff <= 1'b1;
      end else if (!rsp_stall) begin
         o_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         o_pix_ff  <= center_bit && !removed;
         o_rem_ff  <= removed;
         o_last_ff <= s1_last_ff;
         o_chg_ff  <= s1_last_ff && (any_ff || removed);
      end
   end

   // Accumulate removals over the frame, clear after the final result
   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         any_ff <= !s1_last_ff && (any_ff || removed);
      end
   end

   assign rsp_valid         = o_v_ff;
   assign rsp_pixel_out     = o_pix_ff;
   assign rsp_removed       = o_rem_ff;
   assign rsp_frame_last    = o_last_ff;
   assign rsp_frame_changed = o_chg_ff;

   // Stage 1 holds its beat while a result cannot leave
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_emit_ff && o_v_ff && rsp_stall) |=> s1_v_ff)
      else $error("stage 1 beat lost while output blocked");

   // Input backs up only behind an occupied stage 1
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_v_ff)
      else $error("input stalled with stage 1 empty");

   // A removal is remembered or reported on the final result
   a_any_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_emit_ff && removed) |=> (any_ff || o_last_ff))
      else $error("removal not recorded");

endmodule

// ===== sim/tb.sv =====
module tb;
   import zst_pkg::*;

   localparam int LINE_DEPTH      = 1024;
   localparam int HEIGHT_MAX      = 4096;
   localparam int SETTLE_CYCLES   = 8;
   localparam int IDLE_LIMIT      = 5000;
   localparam int FRAMES_PER_MODE = 3;

   typedef struct packed {
      logic pixel_in;
      logic drain;
   } pixel_beat_type;

   typedef struct packed {
      logic pixel_out;
      logic removed;
      logic frame_last;
      logic frame_changed;
   } thin_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_pixel_in = 1'b0;
   logic              req_drain = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_pixel_out;
   logic              rsp_removed;
   logic              rsp_frame_last;
   logic              rsp_frame_changed;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Stimulus and expectation stores
   pixel_beat_type  pixel_beats[$];
   thin_result_type expected_pixels[$];
   pixel_beat_type  next_beat;
   thin_result_type got_px, want_px;

   // Predictor copy of the configuration and the frame state
   logic [FW_W-1:0] cfg_width;
   logic [FH_W-1:0] cfg_height;
   logic            cfg_sub;
   logic            line_upper [LINE_DEPTH];
   logic            line_middle [LINE_DEPTH];
   logic [8:0]      zs_window;
   int              row_cnt;
   int              col_cnt;
   logic            any_cleared;

   int  send_gap_pct = 36;
   int  recv_stall_pct = 74;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;
   int  stuck_cycles = 0;
   int  mismatches = 0;

   zhang_suen_thinning_pass #(.MAX_WIDTH(LINE_DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_in      (req_pixel_in),
      .req_drain         (req_drain),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_removed       (rsp_removed),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_frame_changed (rsp_frame_changed),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int clamp_dim(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Removal test on the 3x3 window; ring runs clockwise from the pixel above
   function automatic logic zs_erodes(input logic [8:0] wb, input logic sub);
      logic ring [9];
      int   trans;
      int   nbrs;
      logic m1, m2;
      ring[0] = wb[1];
      ring[1] = wb[2];
      ring[2] = wb[5];
      ring[3] = wb[8];
      ring[4] = wb[7];
      ring[5] = wb[6];
      ring[6] = wb[3];
      ring[7] = wb[0];
      ring[8] = wb[1];
      trans = 0;
      nbrs = 0;
      for (int i = 0; i < 8; i++) begin
         if (!ring[i] && ring[i+1]) trans++;
         nbrs += int'(ring[i]);
      end
      if (sub) begin
         m1 = ring[0] & ring[2] & ring[6];
         m2 = ring[0] & ring[4] & ring[6];
      end else begin
         m1 = ring[0] & ring[2] & ring[4];
         m2 = ring[2] & ring[4] & ring[6];
      end
      return trans == 1 && nbrs >= 2 && nbrs <= 6 && !m1 && !m2;
   endfunction

   // Advance the frame state by one accepted beat and queue the result it causes
   task automatic predict_thinned_pixel(input logic px_in, input logic drn);
      int   w_eff, h_eff, row, col, pr, pc;
      logic pix, up, mid, center, cleared, flushing, last_beat;
      thin_result_type res;
      w_eff = clamp_dim(int'(cfg_width), MIN_DIM, LINE_DEPTH);
      h_eff = clamp_dim(int'(cfg_height), MIN_DIM, HEIGHT_MAX);
      if (col_cnt >= w_eff) begin
         col_cnt = 0;
         row_cnt++;
      end
      row = row_cnt;
      col = col_cnt;
      flushing = row >= h_eff;
      last_beat = row >= h_eff + 1;
      // drop drains that arrive before the frame is complete
      if (!flushing && drn) return;
      if (last_beat) col = 0;
      pix = flushing ? 1'b0 : px_in;

      up = line_upper[col];
      mid = line_middle[col];
      line_upper[col] = mid;
      line_middle[col] = pix;
      zs_window = {pix, zs_window[8:7], mid, zs_window[5:4], up, zs_window[2:1]};

      if (last_beat) begin
         row_cnt = 0;
         col_cnt = 0;
      end else begin
         col_cnt++;
         if (col_cnt >= w_eff) begin
            col_cnt = 0;
            row_cnt++;
         end
      end

      // hold off until the window covers a real pixel
      if (!(row >= 2 || (row == 1 && col >= 1))) return;
      if (col >= 1) begin
         pr = row - 1;
         pc = col - 1;
      end else begin
         pr = row - 2;
         pc = w_eff - 1;
      end

      center = zs_window[4];
      cleared = 1'b0;
      if (center && pr >= 1 && pr + 2 <= h_eff && pc >= 1 && pc + 2 <= w_eff)
         cleared = zs_erodes(zs_window, cfg_sub);
      any_cleared = any_cleared | cleared;

      res.pixel_out = center & ~cleared;
      res.removed = cleared;
      res.frame_last = last_beat;
      res.frame_changed = last_beat ? any_cleared : 1'b0;
      if (last_beat) any_cleared = 1'b0;
      expected_pixels.push_back(res);
   endtask

   // Present the next pending beat, or idle at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_beats.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            next_beat = pixel_beats.pop_front();
            req_valid <= 1'b1;
            req_pixel_in <= next_beat.pixel_in;
            req_drain <= next_beat.drain;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Predict on each accepted input beat, check each accepted result beat
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && (rsp_valid === 1'b1) && !rsp_stall;
      if (req_taken) predict_thinned_pixel(req_pixel_in, req_drain);
      if (rsp_taken) begin
         got_px = {rsp_pixel_out, rsp_removed, rsp_frame_last, rsp_frame_changed};
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat: expected none, actual %b", $time, got_px);
         end else begin
            want_px = expected_pixels.pop_front();
            if (got_px !== want_px) begin
               mismatches++;
               $display("%0t: mismatch: expected out=%b rem=%b last=%b chg=%b,",
                        $time, want_px.pixel_out, want_px.removed,
                        want_px.frame_last, want_px.frame_changed,
                        " actual out=%b rem=%b last=%b chg=%b",
                        got_px.pixel_out, got_px.removed,
                        got_px.frame_last, got_px.frame_changed);
            end
         end
      end
      // watchdog on cycles without any beat
      if (reset || req_taken || rsp_taken) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= IDLE_LIMIT) begin
            $display("zhang_suen_thinning_pass test failed");
            $finish;
         end
      end
   end

   // APB write: setup cycle, then access cycle
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_FRAME_WIDTH:   cfg_width = val[FW_W-1:0];
         REG_FRAME_HEIGHT:  cfg_height = val[FH_W-1:0];
         REG_SUB_ITERATION: cfg_sub = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Wait until every beat is sent and every result is back, then let the pipe settle
   task automatic wait_idle();
      while (pixel_beats.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_beat(input logic px, input logic drn);
      pixel_beat_type b;
      b.pixel_in = px;
      b.drain = drn;
      pixel_beats.push_back(b);
   endtask

   // Queue one frame for the current setting; finish any frame left open first
   task automatic queue_frame(input int density, input bit pause_mid);
      int w_eff, h_eff, n_px, pos, tail, flush_len;
      w_eff = clamp_dim(int'(cfg_width), MIN_DIM, LINE_DEPTH);
      h_eff = clamp_dim(int'(cfg_height), MIN_DIM, HEIGHT_MAX);
      if (row_cnt != 0 || col_cnt != 0) begin
         pos = (col_cnt >= w_eff) ? (row_cnt + 1) * w_eff : row_cnt * w_eff + col_cnt;
         tail = ((h_eff + 1) * w_eff > pos) ? (h_eff + 1) * w_eff - pos : 0;
         for (int i = 0; i <= tail; i++) push_beat(1'($urandom_range(1)), 1'b0);
      end
      n_px = w_eff * h_eff;
      for (int i = 0; i < n_px; i++) begin
         if (pause_mid && i == n_px / 2) wait_idle();
         // stray drain inside the frame is ignored by the block
         if ($urandom_range(19) == 0) push_beat(1'($urandom_range(1)), 1'b1);
         push_beat($urandom_range(99) < density, 1'b0);
      end
      flush_len = w_eff + 1;
      if ($urandom_range(9) == 0) flush_len = $urandom_range(w_eff);
      for (int i = 0; i < flush_len; i++)
         push_beat(1'($urandom_range(1)), $urandom_range(4) != 0);
      if ($urandom_range(9) == 0) begin
         for (int i = 0; i < 3; i++) push_beat(1'($urandom_range(1)), 1'b1);
      end
   endtask

   initial begin
      logic [15:0] pattern;
      int          density;
      cfg_width = FW_RESET;
      cfg_height = FH_RESET;
      cfg_sub = 1'b0;
      zs_window = '0;
      row_cnt = 0;
      col_cnt = 0;
      any_cleared = 1'b0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_upper[i] = 1'b0;
         line_middle[i] = 1'b0;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed 4x4 frame: start-up, stray drain, pixel during flush
      csr_write(REG_FRAME_WIDTH, 4);
      csr_write(REG_FRAME_HEIGHT, 4);
      csr_write(REG_SUB_ITERATION, 0);
      pattern = 16'b0110_1111_1110_0100;
      for (int i = 15; i >= 0; i--) begin
         push_beat(pattern[i], 1'b0);
         if (i == 11) push_beat(1'b1, 1'b1);
      end
      push_beat(1'b0, 1'b1);
      push_beat(1'b1, 1'b1);
      push_beat(1'b1, 1'b0);
      push_beat(1'b0, 1'b1);
      push_beat(1'b0, 1'b1);
      wait_idle();

      // Width saturates from above: run one full row and a few pixels, then
      // close the frame at the narrowest width (row 2, flush row, final beat)
      csr_write(REG_FRAME_WIDTH, 2047);
      csr_write(REG_FRAME_HEIGHT, 3);
      csr_write(REG_SUB_ITERATION, 1);
      for (int i = 0; i < LINE_DEPTH + 6; i++) push_beat(1'($urandom_range(1)), 1'b0);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, 3);
      for (int i = 0; i < 3; i++) push_beat(1'($urandom_range(1)), 1'b0);
      for (int i = 0; i < 4; i++) push_beat(1'($urandom_range(1)), 1'b1);
      wait_idle();

      // Tallest setting, then cut the frame short by lowering the height
      csr_write(REG_FRAME_WIDTH, 3);
      csr_write(REG_FRAME_HEIGHT, 8191);
      for (int i = 0; i < 18; i++) push_beat(1'($urandom_range(1)), 1'b0);
      wait_idle();
      csr_write(REG_FRAME_HEIGHT, 3);
      push_beat(1'b1, 1'b1);
      push_beat(1'b1, 1'b1);
      wait_idle();

      // Shrink the width in the middle of a row
      csr_write(REG_FRAME_WIDTH, 8);
      csr_write(REG_FRAME_HEIGHT, 5);
      csr_write(REG_SUB_ITERATION, 0);
      for (int i = 0; i < 20; i++) push_beat(1'($urandom_range(1)), 1'b0);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, 0);
      queue_frame(60, 1'b0);
      wait_idle();

      // Random frames under three idle profiles
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_gap_pct = 36;
               recv_stall_pct = 74;
            end
            1: begin
               send_gap_pct = 74;
               recv_stall_pct = 36;
            end
            default: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int f = 0; f < FRAMES_PER_MODE; f++) begin
            wait_idle();
            csr_write(REG_FRAME_WIDTH,
                      ($urandom_range(19) == 0) ? $urandom_range(2) : $urandom_range(10, 3));
            csr_write(REG_FRAME_HEIGHT,
                      ($urandom_range(19) == 0) ? $urandom_range(2) : $urandom_range(8, 3));
            csr_write(REG_SUB_ITERATION, $urandom_range(1));
            case ($urandom_range(4))
               0: density = 10;
               1: density = 30;
               2: density = 50;
               3: density = 70;
               default: density = 92;
            endcase
            queue_frame(density, f == 2);
         end
      end
      wait_idle();

      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("zhang_suen_thinning_pass test passed");
      end else begin
         $display("zhang_suen_thinning_pass test failed");
      end
      $finish;
   end
endmodule

// ===== zhang_suen_thinning_pass.f =====
rtl/core/zst_pkg.sv
rtl/core/zst_ram.sv
rtl/core/zst_csr.sv
rtl/core/zst_scan.sv
rtl/core/zst_window.sv
rtl/core/zhang_suen_thinning_pass.sv
sim/tb.sv
